@@ src/sne_pkg.sv @@
// ----------------------------------------------------------------------------
// sne_pkg
// Register indexes, sequencer states and control word of the spiking neuron
// Euler stepper.
// ----------------------------------------------------------------------------
package sne_pkg;

  localparam int unsigned CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_RATE        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SENSITIVITY = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_POTENTIAL      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_JUMP        = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_POTENTIAL       = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_COEFFICIENT   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COEFFICIENT   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_TERM        = 4'd7;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_REINIT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_ADD1,
    ST_MUL2,
    ST_ADD2,
    ST_ADD3,
    ST_ADD4,
    ST_MUL3,
    ST_ADD5,
    ST_MUL4,
    ST_MUL5,
    ST_ADD6,
    ST_MUL6,
    ST_ADD7,
    ST_SPK,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_ALPHA_V,
    MUL_T_V,
    MUL_DT_T,
    MUL_DT_A,
    MUL_B_VN,
    MUL_K_E
  } mul_op_t;

  typedef enum logic [2:0] {
    ADD_Q_BETA,
    ADD_Q_GAMMA,
    ADD_T_SUB_U,
    ADD_T_DRIVE,
    ADD_V_Q,
    ADD_Q_SUB_U,
    ADD_U_Q,
    ADD_UN_D
  } add_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    mul_en;
    add_op_t add_op;
    logic    t_ld;
    logic    vn_ld;
    logic    un_ld;
    logic    k_ld;
    logic    spk_ld;
  } ctrl_t;

endpackage

@@ src/spiking_neuron_euler_step.sv @@
// ----------------------------------------------------------------------------
// spiking_neuron_euler_step
// One Izhikevich neuron stepped by forward Euler in signed Q16.16, built
// around one shared 32x32 multiplier and one saturating adder.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | operation, time_step, drive, start_*
//  out_    | output    | out_valid/out_stall | reported_potential, recovery_out, spike
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  A tick word walks 14 sequencer steps (six multiplies, eight adds, one
//  per cycle through the shared units), posts its result from the last
//  step and returns to idle to take the next word. A reinit word goes
//  straight to the last step. A pending result does not block the next
//  accept; a finished word waits there while the held result is stalled.
//  Reset (rst_n low, synchronous) loads register defaults and v = -65 mV,
//  u = -13.
// ----------------------------------------------------------------------------
module spiking_neuron_euler_step
  import sne_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [16:0]                 in_time_step,
  input  logic signed [31:0]          in_drive,
  input  logic signed [24:0]          in_start_potential,
  input  logic signed [24:0]          in_start_recovery,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_reported_potential,
  output logic signed [31:0]          out_recovery_out,
  output logic                        out_spike,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data
);

  localparam logic signed [47:0] Q_MAX = 48'sd2147483647;
  localparam logic signed [47:0] Q_MIN = -48'sd2147483648;
  localparam logic signed [33:0] S_MAX = 34'sd2147483647;
  localparam logic signed [33:0] S_MIN = -34'sd2147483648;

  // configuration
  logic [16:0]        a_r;
  logic [18:0]        b_r;
  logic signed [24:0] c_r;
  logic signed [24:0] d_r;
  logic signed [24:0] peak_r;
  logic [16:0]        alpha_r;
  logic [20:0]        beta_r;
  logic signed [25:0] gamma_r;

  // neuron state and working registers
  state_t             state_r, state_nxt;
  ctrl_t              ctrl;
  logic signed [31:0] v_r, u_r;
  logic signed [31:0] t_r, vn_r, un_r, k_r;
  logic signed [63:0] p_r;
  logic [16:0]        dt_r;
  logic signed [31:0] drive_r;
  logic signed [31:0] res_v_r, res_u_r;
  logic               res_spk_r;
  logic               out_valid_r;
  logic signed [31:0] out_v_r, out_u_r;
  logic               out_spk_r;

  logic               in_acc, out_free, spike_hit;
  logic signed [31:0] mul_x, mul_y, add_x, add_y, q_sat, sum_sat;
  logic               add_sub;
  logic signed [47:0] q_wide;
  logic signed [33:0] sum_wide;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign spike_hit = (vn_r >= 32'(peak_r));

  assign out_valid              = out_valid_r;
  assign out_reported_potential = out_v_r;
  assign out_recovery_out       = out_u_r;
  assign out_spike              = out_spk_r;

  // product back to Q16.16: floor shift, then saturate
  assign q_wide = p_r[63:16];
  always_comb begin
    if (q_wide > Q_MAX) begin
      q_sat = 32'sh7FFFFFFF;
    end else if (q_wide < Q_MIN) begin
      q_sat = 32'sh80000000;
    end else begin
      q_sat = q_wide[31:0];
    end
  end

  // multiplier operand select
  always_comb begin
    case (ctrl.mul_op)
      MUL_ALPHA_V: begin mul_x = signed'({15'd0, alpha_r}); mul_y = v_r;  end
      MUL_T_V:     begin mul_x = t_r;                       mul_y = v_r;  end
      MUL_DT_T:    begin mul_x = signed'({15'd0, dt_r});    mul_y = t_r;  end
      MUL_DT_A:    begin
        mul_x = signed'({15'd0, dt_r});
        mul_y = signed'({15'd0, a_r});
      end
      MUL_B_VN:    begin mul_x = signed'({13'd0, b_r});     mul_y = vn_r; end
      MUL_K_E:     begin mul_x = k_r;                       mul_y = t_r;  end
      default:     begin mul_x = t_r;                       mul_y = v_r;  end
    endcase
  end

  // adder operand select
  always_comb begin
    add_sub = 1'b0;
    case (ctrl.add_op)
      ADD_Q_BETA:  begin add_x = q_sat; add_y = signed'({11'd0, beta_r}); end
      ADD_Q_GAMMA: begin add_x = q_sat; add_y = 32'(gamma_r);            end
      ADD_T_SUB_U: begin add_x = t_r;   add_y = u_r; add_sub = 1'b1;     end
      ADD_T_DRIVE: begin add_x = t_r;   add_y = drive_r;                 end
      ADD_V_Q:     begin add_x = v_r;   add_y = q_sat;                   end
      ADD_Q_SUB_U: begin add_x = q_sat; add_y = u_r; add_sub = 1'b1;     end
      ADD_U_Q:     begin add_x = u_r;   add_y = q_sat;                   end
      ADD_UN_D:    begin add_x = un_r;  add_y = 32'(d_r);                end
      default:     begin add_x = t_r;   add_y = u_r;                     end
    endcase
  end

  assign sum_wide = add_sub ? (34'(add_x) - 34'(add_y)) : (34'(add_x) + 34'(add_y));
  always_comb begin
    if (sum_wide > S_MAX) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum_wide < S_MIN) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_wide[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_operation == OP_REINIT) ? ST_FIN : ST_MUL1;
        end
      end
      ST_MUL1: state_nxt = ST_ADD1;
      ST_ADD1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_ADD2;
      ST_ADD2: state_nxt = ST_ADD3;
      ST_ADD3: state_nxt = ST_ADD4;
      ST_ADD4: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_ADD5;
      ST_ADD5: state_nxt = ST_MUL4;
      ST_MUL4: state_nxt = ST_MUL5;
      ST_MUL5: state_nxt = ST_ADD6;
      ST_ADD6: state_nxt = ST_MUL6;
      ST_MUL6: state_nxt = ST_ADD7;
      ST_ADD7: state_nxt = ST_SPK;
      ST_SPK:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control word per step
  always_comb begin
    ctrl = '{mul_op: MUL_T_V, mul_en: 1'b0, add_op: ADD_Q_BETA, t_ld: 1'b0,
             vn_ld: 1'b0, un_ld: 1'b0, k_ld: 1'b0, spk_ld: 1'b0};
    case (state_r)
      ST_MUL1: begin ctrl.mul_op = MUL_ALPHA_V; ctrl.mul_en = 1'b1; end
      ST_ADD1: begin ctrl.add_op = ADD_Q_BETA;  ctrl.t_ld = 1'b1;   end
      ST_MUL2: begin ctrl.mul_op = MUL_T_V;     ctrl.mul_en = 1'b1; end
      ST_ADD2: begin ctrl.add_op = ADD_Q_GAMMA; ctrl.t_ld = 1'b1;   end
      ST_ADD3: begin ctrl.add_op = ADD_T_SUB_U; ctrl.t_ld = 1'b1;   end
      ST_ADD4: begin ctrl.add_op = ADD_T_DRIVE; ctrl.t_ld = 1'b1;   end
      ST_MUL3: begin ctrl.mul_op = MUL_DT_T;    ctrl.mul_en = 1'b1; end
      ST_ADD5: begin ctrl.add_op = ADD_V_Q;     ctrl.vn_ld = 1'b1;  end
      ST_MUL4: begin ctrl.mul_op = MUL_DT_A;    ctrl.mul_en = 1'b1; end
      // capture k from the dt*a product while b*v' starts
      ST_MUL5: begin ctrl.mul_op = MUL_B_VN; ctrl.mul_en = 1'b1; ctrl.k_ld = 1'b1; end
      ST_ADD6: begin ctrl.add_op = ADD_Q_SUB_U; ctrl.t_ld = 1'b1;   end
      ST_MUL6: begin ctrl.mul_op = MUL_K_E;     ctrl.mul_en = 1'b1; end
      ST_ADD7: begin ctrl.add_op = ADD_U_Q;     ctrl.un_ld = 1'b1;  end
      ST_SPK:  begin ctrl.add_op = ADD_UN_D;    ctrl.spk_ld = 1'b1; end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      p_r <= mul_x * mul_y;
    end
    if (ctrl.t_ld) begin
      t_r <= sum_sat;
    end
    if (ctrl.vn_ld) begin
      vn_r <= sum_sat;
    end
    if (ctrl.un_ld) begin
      un_r <= sum_sat;
    end
    if (ctrl.k_ld) begin
      k_r <= q_sat;
    end
    if (in_acc) begin
      dt_r    <= in_time_step;
      drive_r <= in_drive;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_REINIT) begin
      res_v_r   <= 32'(in_start_potential);
      res_u_r   <= 32'(in_start_recovery);
      res_spk_r <= 1'b0;
    end else if (ctrl.spk_ld) begin
      if (spike_hit) begin
        res_v_r <= 32'(peak_r);
        res_u_r <= sum_sat;
      end else begin
        res_v_r <= vn_r;
        res_u_r <= un_r;
      end
      res_spk_r <= spike_hit;
    end
    if (state_r == ST_FIN && out_free) begin
      out_v_r   <= res_v_r;
      out_u_r   <= res_u_r;
      out_spk_r <= res_spk_r;
    end
  end

  // control, neuron state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v_r         <= -32'sd4259840;
      u_r         <= -32'sd851968;
      a_r         <= 17'd1311;
      b_r         <= 19'd13107;
      c_r         <= -25'sd4259840;
      d_r         <= 25'sd131072;
      peak_r      <= 25'sd1966080;
      alpha_r     <= 17'd2621;
      beta_r      <= 21'd327680;
      gamma_r     <= 26'sd9175040;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_acc && in_operation == OP_REINIT) begin
        v_r <= 32'(in_start_potential);
        u_r <= 32'(in_start_recovery);
      end else if (ctrl.spk_ld) begin
        // drop to reset potential and kick recovery on a spike
        v_r <= spike_hit ? 32'(c_r) : vn_r;
        u_r <= spike_hit ? sum_sat : un_r;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RECOVERY_RATE:        a_r     <= cfg_data[16:0];
          REG_RECOVERY_SENSITIVITY: b_r     <= cfg_data[18:0];
          REG_RESET_POTENTIAL:      c_r     <= signed'(cfg_data[24:0]);
          REG_RECOVERY_JUMP:        d_r     <= signed'(cfg_data[24:0]);
          REG_PEAK_POTENTIAL:       peak_r  <= signed'(cfg_data[24:0]);
          REG_SQUARE_COEFFICIENT:   alpha_r <= cfg_data[16:0];
          REG_LINEAR_COEFFICIENT:   beta_r  <= cfg_data[20:0];
          REG_CONSTANT_TERM:        gamma_r <= signed'(cfg_data[25:0]);
          default: ;
        endcase
      end
    end
  end

  // assertions
  a_spike_at_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_spk_r) |-> (out_v_r == 32'(peak_r)))
    else $error("spike result does not report the peak potential");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("finished word left its step while output was blocked");

  a_spike_resets_v: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPK && spike_hit) |=> (v_r == 32'($past(c_r)) && res_spk_r))
    else $error("potential not reset after spike");

  a_reinit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_REINIT) |=>
      (state_r == ST_FIN && v_r == 32'($past(in_start_potential))))
    else $error("reinit did not load the start potential");

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Izhikevich Euler stepper. A predictor in the
// bench tracks potential, recovery and the eight parameter registers; every
// result word is compared with the oldest prediction. Directed edge words,
// register extremes, random neuron traffic under three idling mixes and a
// long output hold are run in turn.
// ----------------------------------------------------------------------------
module tb_top;
  import sne_pkg::*;

  localparam int REG_COUNT      = 8;
  localparam int SETTLE_CYCLES  = 24;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint Q_MAX      = 64'sd2147483647;
  localparam longint Q_MIN      = -64'sd2147483648;

  typedef struct {
    logic               operation;
    logic [16:0]        time_step;
    logic signed [31:0] drive;
    logic signed [24:0] start_potential;
    logic signed [24:0] start_recovery;
  } neuron_word_t;

  typedef struct {
    logic signed [31:0] reported_potential;
    logic signed [31:0] recovery_out;
    logic               spike;
  } neuron_result_t;

  typedef enum {
    PARAMS_REGULAR,
    PARAMS_CHATTER,
    PARAMS_FAST,
    PARAMS_RANDOM,
    PARAMS_HIGHS,
    PARAMS_LOWS,
    PARAMS_RAW
  } param_set_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_operation;
  logic [16:0]          in_time_step;
  logic signed [31:0]   in_drive;
  logic signed [24:0]   in_start_potential;
  logic signed [24:0]   in_start_recovery;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [31:0]   out_reported_potential;
  logic signed [31:0]   out_recovery_out;
  logic                 out_spike;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // predicted neuron: parameters and state
  longint a_rate      = 1311;
  longint b_sens      = 13107;
  longint c_reset     = -4259840;
  longint d_jump      = 131072;
  longint v_peak      = 1966080;
  longint alpha_sq    = 2621;
  longint beta_lin    = 327680;
  longint gamma_const = 9175040;
  longint v_now       = -4259840;
  longint u_now       = -851968;

  neuron_result_t pending_neuron_states[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_orders = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int words_sent = 0;
  int reinits_sent = 0;
  int results_checked = 0;
  int spikes_seen = 0;
  int reg_writes = 0;

  spiking_neuron_euler_step dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_operation           (in_operation),
    .in_time_step           (in_time_step),
    .in_drive               (in_drive),
    .in_start_potential     (in_start_potential),
    .in_start_recovery      (in_start_recovery),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_reported_potential (out_reported_potential),
    .out_recovery_out       (out_recovery_out),
    .out_spike              (out_spike),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat32(longint x);
    if (x > Q_MAX) return Q_MAX;
    if (x < Q_MIN) return Q_MIN;
    return x;
  endfunction

  // Q16.16 product, floor rounding via arithmetic shift
  function automatic longint qmul(longint x, longint y);
    return sat32((x * y) >>> 16);
  endfunction

  function automatic longint field_at(logic [31:0] raw, int width, bit is_signed);
    longint x;
    x = longint'({32'd0, raw}) & ((64'sd1 << width) - 64'sd1);
    if (is_signed && x[width-1]) x = x - (64'sd1 << width);
    return x;
  endfunction

  function automatic neuron_result_t advance_neuron(neuron_word_t w);
    neuron_result_t r;
    longint dt, t, k, e, vn, un;
    if (w.operation == OP_REINIT) begin
      v_now = longint'(w.start_potential);
      u_now = longint'(w.start_recovery);
      r.reported_potential = 32'(v_now);
      r.recovery_out = 32'(u_now);
      r.spike = 1'b0;
      return r;
    end
    dt = longint'(w.time_step);
    t = sat32(qmul(alpha_sq, v_now) + beta_lin);
    t = qmul(t, v_now);
    t = sat32(t + gamma_const);
    t = sat32(t - u_now);
    t = sat32(t + longint'(w.drive));
    vn = sat32(v_now + qmul(dt, t));
    k = qmul(dt, a_rate);
    e = sat32(qmul(b_sens, vn) - u_now);
    un = sat32(u_now + qmul(k, e));
    r.spike = (vn >= v_peak);
    if (r.spike) begin
      r.reported_potential = 32'(v_peak);
      vn = c_reset;
      un = sat32(un + d_jump);
    end else begin
      r.reported_potential = 32'(vn);
    end
    v_now = vn;
    u_now = un;
    r.recovery_out = 32'(un);
    return r;
  endfunction

  function automatic neuron_word_t tick_word(logic [16:0] dt, logic [31:0] drive);
    neuron_word_t w;
    w.operation = OP_TICK;
    w.time_step = dt;
    w.drive = drive;
    w.start_potential = 25'($urandom());
    w.start_recovery = 25'($urandom());
    return w;
  endfunction

  function automatic neuron_word_t reinit_word(logic [24:0] v0, logic [24:0] u0);
    neuron_word_t w;
    w.operation = OP_REINIT;
    w.time_step = 17'($urandom());
    w.drive = $urandom();
    w.start_potential = v0;
    w.start_recovery = u0;
    return w;
  endfunction

  // mostly plausible neuron traffic, the rest raw noise over every field bit
  function automatic neuron_word_t make_word();
    neuron_word_t w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      w = tick_word(17'($urandom_range(3277, 65536)), $urandom_range(0, 1310720) - 65536);
    end else if (pick < 86) begin
      w = reinit_word(25'(-int'($urandom_range(0, 5242880))),
                      25'(int'($urandom_range(0, 1310720)) - 655360));
    end else begin
      w.operation = 1'($urandom_range(1));
      w.time_step = 17'($urandom_range(0, 131071));
      w.drive = $urandom();
      w.start_potential = 25'($urandom());
      w.start_recovery = 25'($urandom());
    end
    return w;
  endfunction

  task automatic send_word(neuron_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= w.operation;
    in_time_step <= w.time_step;
    in_drive <= w.drive;
    in_start_potential <= w.start_potential;
    in_start_recovery <= w.start_recovery;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_neuron_states.push_back(advance_neuron(w));
    words_sent++;
    if (w.operation == OP_REINIT) reinits_sent++;
  endtask

  // drop valid, wait out every pending result, then let the sequencer settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending_neuron_states.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_RECOVERY_RATE:        a_rate      = field_at(data, 17, 1'b0);
      REG_RECOVERY_SENSITIVITY: b_sens      = field_at(data, 19, 1'b0);
      REG_RESET_POTENTIAL:      c_reset     = field_at(data, 25, 1'b1);
      REG_RECOVERY_JUMP:        d_jump      = field_at(data, 25, 1'b1);
      REG_PEAK_POTENTIAL:       v_peak      = field_at(data, 25, 1'b1);
      REG_SQUARE_COEFFICIENT:   alpha_sq    = field_at(data, 17, 1'b0);
      REG_LINEAR_COEFFICIENT:   beta_lin    = field_at(data, 21, 1'b0);
      REG_CONSTANT_TERM:        gamma_const = field_at(data, 26, 1'b1);
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // values listed in register index order: a, b, c, d, peak, alpha, beta, gamma
  task automatic apply_params(param_set_e which);
    logic [31:0] vals [REG_COUNT];
    vals = '{1311, 13107, -4259840, 131072, 1966080, 2621, 327680, 9175040};
    case (which)
      PARAMS_CHATTER: begin
        vals[REG_RESET_POTENTIAL[2:0]] = -3276800;
      end
      PARAMS_FAST: begin
        vals[REG_RECOVERY_RATE[2:0]] = 6554;
      end
      PARAMS_RANDOM: begin
        vals[REG_RECOVERY_RATE[2:0]] = $urandom_range(0, 65536);
        vals[REG_RECOVERY_SENSITIVITY[2:0]] = $urandom_range(0, 262144);
        vals[REG_RESET_POTENTIAL[2:0]] = int'($urandom_range(0, 16777216)) - 8388608;
        vals[REG_RECOVERY_JUMP[2:0]] = int'($urandom_range(0, 16777216)) - 8388608;
        vals[REG_PEAK_POTENTIAL[2:0]] = int'($urandom_range(0, 16777216)) - 8388608;
        vals[REG_SQUARE_COEFFICIENT[2:0]] = $urandom_range(0, 65536);
        vals[REG_LINEAR_COEFFICIENT[2:0]] = $urandom_range(0, 1048576);
        vals[REG_CONSTANT_TERM[2:0]] = int'($urandom_range(0, 33554432)) - 16777216;
      end
      PARAMS_HIGHS: begin
        vals = '{65536, 262144, 8388608, 8388608, 8388608, 65536, 1048576, 16777216};
      end
      PARAMS_LOWS: begin
        vals = '{0, 0, -8388608, -8388608, -8388608, 0, 0, -16777216};
      end
      PARAMS_RAW: begin
        foreach (vals[i]) vals[i] = $urandom();
      end
      default: ;
    endcase
    for (int i = 0; i < REG_COUNT; i++) write_reg(i[CFG_IDX_W-1:0], vals[i[2:0]]);
  endtask

  task automatic test_directed_edges();
    set_idling(0, 0);
    send_word(tick_word(17'd0, 32'sd0));
    send_word(tick_word(17'd32768, 32'sd655360));
    send_word(tick_word(17'd65536, 32'sd0));
    send_word(tick_word(17'h1FFFF, 32'sd0));
    send_word(tick_word(17'd65536, 32'h7FFFFFFF));
    send_word(tick_word(17'd65536, 32'h80000000));
    send_word(reinit_word(25'h0FFFFFF, 25'h1000000));
    send_word(tick_word(17'd65536, 32'sd0));
    send_word(reinit_word(25'h1000000, 25'h0FFFFFF));
    send_word(tick_word(17'd65536, 32'h7FFFFFFF));
    // potential sitting exactly on the peak fires even with a zero step
    send_word(reinit_word(25'd1966080, 25'd0));
    send_word(tick_word(17'd0, 32'sd0));
    send_word(reinit_word(25'd1966079, 25'd0));
    send_word(tick_word(17'd0, 32'sd0));
    send_word(reinit_word(-25'sd4259840, -25'sd851968));
    repeat (8) send_word(tick_word(17'd65536, 32'sd655360));
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    apply_params(PARAMS_HIGHS);
    repeat (10) send_word(make_word());
    wait_results_drained();
    apply_params(PARAMS_LOWS);
    repeat (10) send_word(make_word());
    // indexes past the last register must leave the settings alone
    wait_results_drained();
    for (int i = REG_COUNT; i < (1 << CFG_IDX_W); i++) begin
      write_reg(i[CFG_IDX_W-1:0], $urandom());
    end
    repeat (6) send_word(make_word());
    wait_results_drained();
    apply_params(PARAMS_RAW);
    repeat (10) send_word(make_word());
  endtask

  task automatic test_random_stream(int count, int send_pct, int recv_pct);
    int sent;
    sent = 0;
    while (sent < count) begin
      wait_results_drained();
      apply_params(param_set_e'($urandom_range(PARAMS_RANDOM)));
      set_idling(send_pct, recv_pct);
      repeat (100) send_word(make_word());
      sent += 100;
    end
  endtask

  task automatic test_backpressure_fill();
    wait_results_drained();
    apply_params(PARAMS_REGULAR);
    set_idling(0, 0);
    hold_orders <= hold_orders + 1;
    repeat (40) send_word(make_word());
    wait_results_drained();
    repeat (20) send_word(make_word());
  endtask

  // receiver: random stall, or a long hold when the test orders one
  always @(posedge clk) begin
    if (hold_orders != hold_served) begin
      hold_served = hold_orders;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    neuron_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_neuron_states.size() == 0) begin
        $error("result word with nothing pending: potential %0d", out_reported_potential);
        mismatches++;
      end else begin
        want = pending_neuron_states.pop_front();
        if (out_reported_potential !== want.reported_potential) begin
          $error("reported_potential: expected %0d, got %0d",
                 want.reported_potential, out_reported_potential);
          mismatches++;
        end
        if (out_recovery_out !== want.recovery_out) begin
          $error("recovery_out: expected %0d, got %0d",
                 want.recovery_out, out_recovery_out);
          mismatches++;
        end
        if (out_spike !== want.spike) begin
          $error("spike: expected %0d, got %0d", want.spike, out_spike);
          mismatches++;
        end
        results_checked++;
        if (want.spike) spikes_seen++;
      end
    end
  end

  // watchdog: end the run after too long without any handshake
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_TICK;
    in_time_step <= '0;
    in_drive <= '0;
    in_start_potential <= '0;
    in_start_recovery <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_RECOVERY_RATE;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_register_extremes();
    test_random_stream(300, 26, 77);
    test_random_stream(300, 77, 26);
    test_random_stream(300, 0, 0);
    test_backpressure_fill();
    wait_results_drained();

    $display("covered %0d words (%0d reinit), %0d results checked, %0d spikes",
             words_sent, reinits_sent, results_checked, spikes_seen);
    $display("%0d register writes across default, extreme, random and raw settings",
             reg_writes);
    if (mismatches == 0 && pending_neuron_states.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
